FILE: rtl/hws_pkg.sv
// ----------------------------------------------------------------------------
// hws_pkg
// Shared types, constants and helper functions for the wavefield split block.
// ----------------------------------------------------------------------------
package hws_pkg;

  localparam int MAX_WAVENUMBERS     = 4096;
  localparam int MAX_FREQ_BINS_DEF   = 4097;
  localparam int SQRT_STEPS          = 32;
  localparam int DIV_STEPS           = 32;

  localparam logic        RST_MODE   = 1'b1;
  localparam logic [31:0] RST_FSTEP  = 32'd65536;
  localparam logic [31:0] RST_KSTEP  = 32'd65536;
  localparam logic [31:0] RST_SLOW_P = 32'd65536;
  localparam logic [31:0] RST_SLOW_S = 32'd65536;
  localparam logic [31:0] RST_FLOOR  = 32'd1;
  localparam logic [12:0] RST_KCOUNT = 13'd1024;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_FSTEP  = 3'd1,
    CFG_KSTEP  = 3'd2,
    CFG_SLOW_P = 3'd3,
    CFG_SLOW_S = 3'd4,
    CFG_FLOOR  = 3'd5,
    CFG_KCOUNT = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] second_im;
    logic signed [31:0] second_re;
    logic signed [31:0] first_im;
    logic signed [31:0] first_re;
  } samples_t;

  typedef struct packed {
    samples_t    smp;
    logic [31:0] kx;
    logic        kneg;
    logic [63:0] kx2;
    logic [63:0] rem_p;
    logic [63:0] res_p;
    logic [63:0] rem_s;
    logic [63:0] res_s;
  } sqrt_lane_t;

  typedef struct packed {
    samples_t          smp;
    logic              below_floor;
    logic [3:0][31:0]  dec_val;
    logic              dec_sat;
    logic [63:0]       d;
    logic [3:0]        big;
    logic [3:0]        neg;
    logic [3:0][63:0]  rem;
    logic [3:0][31:0]  dl;
    logic [3:0][31:0]  q;
  } div_lane_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  // unsigned k times signed sample, exact
  function automatic logic signed [64:0] mul_ks(logic [31:0] k, logic signed [31:0] s);
    logic signed [32:0] ks;
    logic signed [64:0] p;
    ks = $signed({1'b0, k});
    p  = ks * s;
    return p;
  endfunction

  function automatic logic signed [65:0] neg_if(logic n, logic signed [64:0] a);
    logic signed [65:0] e;
    e = {a[64], a};
    return n ? -e : e;
  endfunction

  function automatic clip_t clip_q(logic neg, logic [47:0] q);
    clip_t r;
    if (!neg && q > 48'h0000_7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (neg && q > 48'h0000_8000_0000) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = neg ? (~q[31:0] + 32'd1) : q[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/helmholtz_wavefield_split.sv
// ----------------------------------------------------------------------------
// helmholtz_wavefield_split
// Per-bin P/SV wavefield split and recombination in the f-k domain.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output buffer is not full, set by
//   the 32 square root and 32 divider cells that each take one item per cycle
// a two-item output buffer decouples m_tready from s_tready
// reset: synchronous, registers return to their reset values, pipeline empties
module helmholtz_wavefield_split #(
  parameter int MAX_FREQ_BINS = hws_pkg::MAX_FREQ_BINS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // freq_index, wavenumber_index, first_re, first_im, second_re, second_im
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_first_re, out_first_im, out_second_re, out_second_im
  output logic [127:0] m_tdata,
  // small_divisor, saturated
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int FIW = $clog2(MAX_FREQ_BINS);
  localparam int WW  = FIW + 32;

  logic        mode;
  logic [31:0] fstep, kstep, slow_p, slow_s, dfloor;
  logic [12:0] kcount;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= hws_pkg::RST_MODE;
      fstep  <= hws_pkg::RST_FSTEP;
      kstep  <= hws_pkg::RST_KSTEP;
      slow_p <= hws_pkg::RST_SLOW_P;
      slow_s <= hws_pkg::RST_SLOW_S;
      dfloor <= hws_pkg::RST_FLOOR;
      kcount <= hws_pkg::RST_KCOUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        hws_pkg::CFG_MODE:   mode   <= cfg_data[0];
        hws_pkg::CFG_FSTEP:  fstep  <= cfg_data;
        hws_pkg::CFG_KSTEP:  kstep  <= cfg_data;
        hws_pkg::CFG_SLOW_P: slow_p <= cfg_data;
        hws_pkg::CFG_SLOW_S: slow_s <= cfg_data;
        hws_pkg::CFG_FLOOR:  dfloor <= cfg_data;
        hws_pkg::CFG_KCOUNT: kcount <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic       en;
  logic [1:0] fcnt;
  assign en       = (fcnt != 2'd2);
  assign s_tready = en;

  // stage 1: signed bin and clamped frequency index
  logic [12:0]      fi_in, idx_in, cnt, m_c, m1;
  logic [FIW-1:0]   fic_c, fic1;
  logic             kneg_c, kneg1, v1;
  hws_pkg::samples_t smp_in, smp1;

  always_comb begin
    fi_in  = s_tdata[12:0];
    idx_in = {1'b0, s_tdata[24:13]};
    smp_in.first_re  = s_tdata[56:25];
    smp_in.first_im  = s_tdata[88:57];
    smp_in.second_re = s_tdata[120:89];
    smp_in.second_im = s_tdata[152:121];
    cnt = (32'(kcount) > 32'(hws_pkg::MAX_WAVENUMBERS)) ?
          13'(hws_pkg::MAX_WAVENUMBERS) : kcount;
    kneg_c = 1'b0;
    if (idx_in < (cnt >> 1)) begin
      m_c = idx_in;
    end else if (idx_in >= cnt) begin
      m_c = idx_in - cnt;
    end else begin
      m_c    = cnt - idx_in;
      kneg_c = 1'b1;
    end
    fic_c = (32'(fi_in) > 32'(MAX_FREQ_BINS - 1)) ? FIW'(MAX_FREQ_BINS - 1) : FIW'(fi_in);
  end

  // stage 2: kx and w products
  logic [44:0]       kxr2;
  logic [WW-1:0]     w2;
  logic              kneg2, v2;
  hws_pkg::samples_t smp2;

  // stage 3: saturate kx, partial products for w times slowness
  logic [31:0]       kx3;
  logic [63:0]       plo_p3, plo_s3;
  logic [WW-1:0]     phi_p3, phi_s3;
  logic              kneg3, v3;
  hws_pkg::samples_t smp3;

  // stage 4: w*slowness saturated, kx squared
  logic [31:0]       wp4, ws4, kx4;
  logic [63:0]       kx2_4;
  logic              kneg4, v4;
  hws_pkg::samples_t smp4;
  logic [48:0]       sum_p, sum_s;
  logic [31:0]       wp_c, ws_c;

  // stage 5: squares
  logic [63:0]       sp2_5, ss2_5, kx2_5;
  logic [31:0]       kx5;
  logic              kneg5, v5;
  hws_pkg::samples_t smp5;

  always_comb begin
    sum_p = 49'({phi_p3[15:0], 16'h0000}) + 49'(plo_p3[63:16]);
    sum_s = 49'({phi_s3[15:0], 16'h0000}) + 49'(plo_s3[63:16]);
    wp_c  = ((phi_p3 >> 16) != '0 || sum_p[48:32] != '0) ? 32'hFFFF_FFFF : sum_p[31:0];
    ws_c  = ((phi_s3 >> 16) != '0 || sum_s[48:32] != '0) ? 32'hFFFF_FFFF : sum_s[31:0];
  end

  hws_pkg::sqrt_lane_t sq_lane [hws_pkg::SQRT_STEPS+1];
  logic                sq_valid [hws_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      sq_valid[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1     <= m_c;
      kneg1  <= kneg_c;
      fic1   <= fic_c;
      smp1   <= smp_in;

      kxr2   <= 45'(m1) * 45'(kstep);
      w2     <= WW'(fic1) * WW'(fstep);
      kneg2  <= kneg1;
      smp2   <= smp1;

      kx3    <= (kxr2[44:32] != '0) ? 32'hFFFF_FFFF : kxr2[31:0];
      plo_p3 <= 64'(w2[31:0]) * 64'(slow_p);
      plo_s3 <= 64'(w2[31:0]) * 64'(slow_s);
      phi_p3 <= WW'(w2[WW-1:32]) * WW'(slow_p);
      phi_s3 <= WW'(w2[WW-1:32]) * WW'(slow_s);
      kneg3  <= kneg2;
      smp3   <= smp2;

      wp4    <= wp_c;
      ws4    <= ws_c;
      kx4    <= kx3;
      kx2_4  <= 64'(kx3) * 64'(kx3);
      kneg4  <= kneg3;
      smp4   <= smp3;

      sp2_5  <= 64'(wp4) * 64'(wp4);
      ss2_5  <= 64'(ws4) * 64'(ws4);
      kx2_5  <= kx2_4;
      kx5    <= kx4;
      kneg5  <= kneg4;
      smp5   <= smp4;

      sq_lane[0].smp   <= smp5;
      sq_lane[0].kx    <= kx5;
      sq_lane[0].kneg  <= kneg5;
      sq_lane[0].kx2   <= kx2_5;
      sq_lane[0].rem_p <= (sp2_5 > kx2_5) ? sp2_5 - kx2_5 : 64'd0;
      sq_lane[0].rem_s <= (ss2_5 > kx2_5) ? ss2_5 - kx2_5 : 64'd0;
      sq_lane[0].res_p <= 64'd0;
      sq_lane[0].res_s <= 64'd0;
    end
  end

  for (genvar k = 0; k < hws_pkg::SQRT_STEPS; k++) begin : g_sqrt
    hws_sqrt_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[k]),
      .in_lane   (sq_lane[k]),
      .out_valid (sq_valid[k+1]),
      .out_lane  (sq_lane[k+1])
    );
  end

  // stage 7: component products and kzp*kzs
  hws_pkg::sqrt_lane_t sqo;
  logic [31:0]         kzp, kzs;
  assign sqo = sq_lane[hws_pkg::SQRT_STEPS];
  assign kzp = sqo.res_p[31:0];
  assign kzs = sqo.res_s[31:0];

  logic signed [64:0] pa7, pb7, pc7, pe7, pfi7, pfr7, pgi7, pgr7;
  logic [63:0]        dprod7, kx2_7;
  logic               kneg7, v7;
  hws_pkg::samples_t  smp7;

  // stage 8: signed sums and divisor
  logic signed [65:0] vs8 [4];
  logic [64:0]        dsum;
  logic [63:0]        d8;
  logic               v8;
  hws_pkg::samples_t  smp8;

  assign dsum = 65'(kx2_7) + 65'(dprod7);

  // stage 9: magnitudes, decompose results, divider setup
  hws_pkg::div_lane_t dv_lane [hws_pkg::DIV_STEPS+1];
  logic               dv_valid [hws_pkg::DIV_STEPS+1];
  hws_pkg::div_lane_t lane9;
  logic signed [65:0] av;
  logic [63:0]        mag;
  hws_pkg::clip_t     cq;

  always_comb begin
    lane9             = '0;
    lane9.smp         = smp8;
    lane9.d           = d8;
    lane9.below_floor = (d8 == 64'd0) || (d8 < {16'h0000, dfloor, 16'h0000});
    lane9.dec_sat     = 1'b0;
    av  = '0;
    mag = '0;
    cq  = '0;
    for (int j = 0; j < 4; j++) begin
      av  = vs8[j][65] ? -vs8[j] : vs8[j];
      mag = av[63:0];
      lane9.neg[j]     = vs8[j][65];
      cq               = hws_pkg::clip_q(vs8[j][65], mag[63:16]);
      lane9.dec_val[j] = cq.val;
      lane9.dec_sat    = lane9.dec_sat | cq.sat;
      lane9.big[j]     = ({16'h0000, mag[63:16]} >= d8);
      lane9.rem[j]     = {16'h0000, mag[63:16]};
      lane9.dl[j]      = {mag[15:0], 16'h0000};
      lane9.q[j]       = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      v7 <= sq_valid[hws_pkg::SQRT_STEPS];
      v8 <= v7;
      dv_valid[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa7    <= hws_pkg::mul_ks(sqo.kx, sqo.smp.first_im);
      pb7    <= hws_pkg::mul_ks(sqo.kx, sqo.smp.first_re);
      pc7    <= hws_pkg::mul_ks(sqo.kx, sqo.smp.second_im);
      pe7    <= hws_pkg::mul_ks(sqo.kx, sqo.smp.second_re);
      pfi7   <= hws_pkg::mul_ks(kzs, sqo.smp.second_im);
      pfr7   <= hws_pkg::mul_ks(kzs, sqo.smp.second_re);
      pgi7   <= hws_pkg::mul_ks(kzp, sqo.smp.first_im);
      pgr7   <= hws_pkg::mul_ks(kzp, sqo.smp.first_re);
      dprod7 <= 64'(kzp) * 64'(kzs);
      kx2_7  <= sqo.kx2;
      kneg7  <= sqo.kneg;
      smp7   <= sqo.smp;

      vs8[0] <= hws_pkg::neg_if(!kneg7, pa7) + hws_pkg::neg_if(mode, pfi7);
      vs8[1] <= hws_pkg::neg_if(kneg7, pb7) + hws_pkg::neg_if(!mode, pfr7);
      vs8[2] <= hws_pkg::neg_if(!mode, pgi7) + hws_pkg::neg_if(!kneg7, pc7);
      vs8[3] <= hws_pkg::neg_if(mode, pgr7) + hws_pkg::neg_if(kneg7, pe7);
      d8     <= dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
      smp8   <= smp7;

      dv_lane[0] <= lane9;
    end
  end

  for (genvar k = 0; k < hws_pkg::DIV_STEPS; k++) begin : g_div
    hws_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[k]),
      .in_lane   (dv_lane[k]),
      .out_valid (dv_valid[k+1]),
      .out_lane  (dv_lane[k+1])
    );
  end

  // stage 10: select result
  hws_pkg::div_lane_t dvo;
  logic [127:0]       res_data;
  logic [1:0]         res_user;
  logic               rec_sat;
  hws_pkg::clip_t     cr;
  logic [127:0]       out_data;
  logic [1:0]         out_user;
  logic               v10;

  assign dvo = dv_lane[hws_pkg::DIV_STEPS];

  always_comb begin
    res_data = '0;
    rec_sat  = 1'b0;
    cr       = '0;
    if (mode) begin
      res_data = {dvo.dec_val[3], dvo.dec_val[2], dvo.dec_val[1], dvo.dec_val[0]};
      res_user = {dvo.dec_sat, 1'b0};
    end else if (dvo.below_floor) begin
      res_data = {dvo.smp.first_im, dvo.smp.first_re, dvo.smp.second_im, dvo.smp.second_re};
      res_user = 2'b01;
    end else begin
      for (int j = 0; j < 4; j++) begin
        cr = hws_pkg::clip_q(dvo.neg[j],
                             dvo.big[j] ? 48'hFFFF_FFFF_FFFF : {16'h0000, dvo.q[j]});
        res_data[32*j +: 32] = cr.val;
        rec_sat = rec_sat | cr.sat;
      end
      res_user = {rec_sat, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= dv_valid[hws_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_data;
      out_user <= res_user;
    end
  end

  // output buffer
  logic         push, pop;
  logic [127:0] slot_data;
  logic [1:0]   slot_user;

  assign push     = en & v10;
  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (fcnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= 2'd0;
    end else begin
      fcnt <= 2'(fcnt + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    case (fcnt)
      2'd0: begin
        if (push) begin
          m_tdata <= out_data;
          m_tuser <= out_user;
        end
      end
      2'd1: begin
        if (push && pop) begin
          m_tdata <= out_data;
          m_tuser <= out_user;
        end else if (push) begin
          slot_data <= out_data;
          slot_user <= out_user;
        end
      end
      2'd2: begin
        if (pop) begin
          m_tdata <= slot_data;
          m_tuser <= slot_user;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/hws_sqrt_cell.sv
// ----------------------------------------------------------------------------
// hws_sqrt_cell
// One digit step of the paired floor square roots for kzp and kzs.
// ----------------------------------------------------------------------------
module hws_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  hws_pkg::sqrt_lane_t in_lane,
  output logic                out_valid,
  output hws_pkg::sqrt_lane_t out_lane
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  hws_pkg::sqrt_lane_t lane_next;
  logic [63:0] trial_p, trial_s;

  always_comb begin
    lane_next = in_lane;
    trial_p   = in_lane.res_p + BIT;
    trial_s   = in_lane.res_s + BIT;
    if (in_lane.rem_p >= trial_p) begin
      lane_next.rem_p = in_lane.rem_p - trial_p;
      lane_next.res_p = (in_lane.res_p >> 1) + BIT;
    end else begin
      lane_next.res_p = in_lane.res_p >> 1;
    end
    if (in_lane.rem_s >= trial_s) begin
      lane_next.rem_s = in_lane.rem_s - trial_s;
      lane_next.res_s = (in_lane.res_s >> 1) + BIT;
    end else begin
      lane_next.res_s = in_lane.res_s >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

FILE: rtl/hws_div_cell.sv
// ----------------------------------------------------------------------------
// hws_div_cell
// One restoring quotient bit for each of the four recomposed components.
// ----------------------------------------------------------------------------
module hws_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  hws_pkg::div_lane_t in_lane,
  output logic               out_valid,
  output hws_pkg::div_lane_t out_lane
);

  hws_pkg::div_lane_t lane_next;
  logic [64:0] r2;
  logic        ge;

  always_comb begin
    lane_next = in_lane;
    r2 = '0;
    ge = 1'b0;
    for (int j = 0; j < 4; j++) begin
      r2 = {in_lane.rem[j], in_lane.dl[j][31]};
      ge = (r2 >= {1'b0, in_lane.d});
      lane_next.rem[j] = ge ? 64'(r2 - {1'b0, in_lane.d}) : r2[63:0];
      lane_next.dl[j]  = {in_lane.dl[j][30:0], 1'b0};
      lane_next.q[j]   = {in_lane.q[j][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

FILE: rtl/hws_checker.sv
// ----------------------------------------------------------------------------
// hws_checker
// Port-level checks on the output buffer and stream handshakes.
// ----------------------------------------------------------------------------
module hws_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output item pending");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

endmodule

bind helmholtz_wavefield_split hws_checker u_hws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: dv/helmholtz_wavefield_split_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// helmholtz_wavefield_split_checker
// Watches the config, input and output channels of the wavefield split block,
// keeps its own copy of the registers, predicts each bin's p/s or x/z result
// and compares the outputs field by field in order of arrival.
// ----------------------------------------------------------------------------
module helmholtz_wavefield_split_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [3:0][31:0] comp;
    logic             small_div;
    logic             sat;
  } bin_result_t;

  bin_result_t expected_bins[$];

  logic        decompose;
  logic [31:0] freq_step, k_step, slow_p, slow_s, div_floor;
  logic [12:0] k_count;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'h1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [127:0] sat32(logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 128'hFFFF_FFFF : v;
  endfunction

  function automatic bin_result_t predict_bin(logic [159:0] d);
    bin_result_t r;
    logic [127:0] fi, idx, cnt, m, kx, w, wp, ws, kx2, sp2, ss2, kzp, kzs, dv, mag, q;
    logic signed [127:0] skx, szp, szs, fre, fim, sre, sim;
    logic signed [127:0] v[4];
    logic kneg, neg;
    fi  = d[12:0];
    idx = d[24:13];
    fre = $signed(d[56:25]);
    fim = $signed(d[88:57]);
    sre = $signed(d[120:89]);
    sim = $signed(d[152:121]);
    cnt = (k_count > hws_pkg::MAX_WAVENUMBERS) ? hws_pkg::MAX_WAVENUMBERS : k_count;
    if (fi > hws_pkg::MAX_FREQ_BINS_DEF - 1) fi = hws_pkg::MAX_FREQ_BINS_DEF - 1;
    kneg = 1'b0;
    if (idx < (cnt >> 1)) begin
      m = idx;
    end else if (idx >= cnt) begin
      m = idx - cnt;
    end else begin
      m = cnt - idx;
      kneg = 1'b1;
    end
    kx  = sat32(m * k_step);
    w   = fi * freq_step;
    wp  = sat32((w * slow_p) >> 16);
    ws  = sat32((w * slow_s) >> 16);
    kx2 = kx * kx;
    sp2 = wp * wp;
    ss2 = ws * ws;
    kzp = (sp2 > kx2) ? floor_sqrt(64'(sp2 - kx2)) : 0;
    kzs = (ss2 > kx2) ? floor_sqrt(64'(ss2 - kx2)) : 0;
    skx = kneg ? -$signed(kx) : $signed(kx);
    szp = $signed(kzp);
    szs = $signed(kzs);
    r = '0;
    if (decompose) begin
      v[0] = -skx * fim - szs * sim;
      v[1] =  skx * fre + szs * sre;
      v[2] =  szp * fim - skx * sim;
      v[3] = -szp * fre + skx * sre;
    end else begin
      dv = kzp * kzs + kx2;
      if (dv > 128'hFFFF_FFFF_FFFF_FFFF) dv = 128'hFFFF_FFFF_FFFF_FFFF;
      if (dv == 0 || dv < ({96'b0, div_floor} << 16)) begin
        r.comp[0] = sre[31:0];
        r.comp[1] = sim[31:0];
        r.comp[2] = fre[31:0];
        r.comp[3] = fim[31:0];
        r.small_div = 1'b1;
        return r;
      end
      v[0] = -skx * fim + szs * sim;
      v[1] =  skx * fre - szs * sre;
      v[2] = -szp * fim - skx * sim;
      v[3] =  szp * fre + skx * sre;
    end
    for (int j = 0; j < 4; j++) begin
      neg = v[j] < 0;
      mag = neg ? -v[j] : v[j];
      q = decompose ? (mag >> 16) : ((mag << 16) / dv);
      if (!neg && q > 128'h7FFF_FFFF) begin
        r.comp[j] = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else if (neg && q > 128'h8000_0000) begin
        r.comp[j] = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.comp[j] = neg ? 32'(-q) : q[31:0];
      end
    end
    return r;
  endfunction

  assign pending = expected_bins.size();

  always @(posedge clk) begin
    bin_result_t exp_r, got;
    int bad;
    bad = 0;
    if (rst) begin
      decompose  <= hws_pkg::RST_MODE;
      freq_step  <= hws_pkg::RST_FSTEP;
      k_step     <= hws_pkg::RST_KSTEP;
      slow_p     <= hws_pkg::RST_SLOW_P;
      slow_s     <= hws_pkg::RST_SLOW_S;
      div_floor  <= hws_pkg::RST_FLOOR;
      k_count    <= hws_pkg::RST_KCOUNT;
      expected_bins.delete();
      errors     <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_bins.push_back(predict_bin(s_tdata));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hws_pkg::CFG_MODE:   decompose <= cfg_data[0];
          hws_pkg::CFG_FSTEP:  freq_step <= cfg_data;
          hws_pkg::CFG_KSTEP:  k_step    <= cfg_data;
          hws_pkg::CFG_SLOW_P: slow_p    <= cfg_data;
          hws_pkg::CFG_SLOW_S: slow_s    <= cfg_data;
          hws_pkg::CFG_FLOOR:  div_floor <= cfg_data;
          hws_pkg::CFG_KCOUNT: k_count   <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.comp = m_tdata;
        got.small_div = m_tuser[0];
        got.sat = m_tuser[1];
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected item %h %b", $time, m_tdata, m_tuser);
          bad++;
        end else begin
          exp_r = expected_bins.pop_front();
          for (int j = 0; j < 4; j++)
            if (exp_r.comp[j] !== got.comp[j]) begin
              $display("%0t: component %0d expected %h actual %h",
                       $time, j, exp_r.comp[j], got.comp[j]);
              bad++;
            end
          if (exp_r.small_div !== got.small_div) begin
            $display("%0t: small_divisor expected %b actual %b",
                     $time, exp_r.small_div, got.small_div);
            bad++;
          end
          if (exp_r.sat !== got.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, got.sat);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

FILE: dv/helmholtz_wavefield_split_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// helmholtz_wavefield_split_test
// Drives bins and register settings into the wavefield split block under
// random stalls on both sides, including one long output hold, and reports
// the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module helmholtz_wavefield_split_test;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           errors, pending;
  int           idle_cycles = 0;
  int           gap_pct = 0;
  bit           quiet = 1'b0;

  always #6 clk = ~clk;

  helmholtz_wavefield_split dut (.*);

  helmholtz_wavefield_split_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL helmholtz_wavefield_split");
      $finish;
    end
  end

  // output side stalls, with one long hold while the input keeps coming
  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 1500) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_bin(logic [12:0] fi, logic [11:0] idx,
                          logic [31:0] fre, fim, sre, sim);
    bit ok;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, sim, sre, fim, fre, idx, fi};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    bit ok;
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setting(bit mode);
    logic [31:0] kcnt, flr;
    case ($urandom_range(0, 6))
      0:       kcnt = 2;
      1:       kcnt = 4096;
      2:       kcnt = $urandom_range(0, 1);
      3:       kcnt = 8191;
      default: kcnt = $urandom_range(2, 4096);
    endcase
    case ($urandom_range(0, 5))
      0:       flr = 0;
      1:       flr = 32'hFFFF_FFFF;
      2:       flr = $urandom;
      default: flr = $urandom_range(1, 1 << 20);
    endcase
    write_reg(hws_pkg::CFG_MODE, {31'($urandom), mode});
    write_reg(hws_pkg::CFG_FSTEP, pick_scale());
    write_reg(hws_pkg::CFG_KSTEP, pick_scale());
    write_reg(hws_pkg::CFG_SLOW_P, pick_scale());
    write_reg(hws_pkg::CFG_SLOW_S, pick_scale());
    write_reg(hws_pkg::CFG_FLOOR, flr);
    write_reg(hws_pkg::CFG_KCOUNT, kcnt);
  endtask

  initial begin
    logic [12:0] fi;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, decompose: index and sample extremes
    send_bin(13'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(13'd4096, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_bin(13'd8191, 12'd511, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(13'd1, 12'd512, 32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 32'h1);
    send_bin(13'd700, 12'd1023, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h4000_0000);
    send_bin(13'd900, 12'd1024, 32'h0, 32'h4000_0000, 32'h4000_0000, 32'h0);
    send_bin(13'd4097, 12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_bin(13'd300, 12'd100, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    // recombine: zero divisor, large divisor floor, normal bins
    write_reg(hws_pkg::CFG_MODE, 32'h0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_bin(13'd0, 12'd0, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
    send_bin(13'd200, 12'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(13'd5, 12'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_bin(13'd4096, 12'd1, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'h1);
    send_bin(13'd50, 12'd2000, 32'hFFFF_FFFF, 32'h1, 32'h4000_0000, 32'h0);
    drain();
    write_reg(hws_pkg::CFG_FLOOR, 32'hFFFF_FFFF);
    send_bin(13'd4096, 12'd511, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'h8000_0000);
    drain();

    // degenerate bin counts
    write_reg(hws_pkg::CFG_FLOOR, 32'h0);
    write_reg(hws_pkg::CFG_KCOUNT, 32'd0);
    send_bin(13'd10, 12'd4095, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    drain();
    write_reg(hws_pkg::CFG_KCOUNT, 32'd1);
    send_bin(13'd10, 12'd0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    send_bin(13'd10, 12'd1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    drain();
    write_reg(hws_pkg::CFG_KCOUNT, 32'hFFFF_FFFF);
    send_bin(13'd3000, 12'd2048, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    send_bin(13'd3000, 12'd2047, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) quiet = 1'b1;
      gap_pct = (ph % 4 == 0) ? 0 : $urandom_range(5, 40);
      random_setting(ph[0]);
      for (int n = 0; n < 118; n++) begin
        fi = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
        send_bin(fi, 12'($urandom), pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS helmholtz_wavefield_split");
    else
      $display("FAIL helmholtz_wavefield_split");
    $finish;
  end

endmodule
